// ----- hdl/go_back_n_sender_unit_defines.svh -----
// assertion macros shared by the go-back-n sender checker
`ifndef GO_BACK_N_SENDER_UNIT_DEFINES_SVH
`define GO_BACK_N_SENDER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define GBN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define GBN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gbn_pkg.sv -----
// types, codes and constants of the go-back-n sender
package gbn_pkg;

    localparam int RING_SLOTS_DEF    = 64;
    localparam int PAYLOAD_BYTES_DEF = 20;
    localparam int PAYLOAD_W         = 160;
    localparam int WIN_MAX           = 32;
    localparam int WINDOW_RESET      = 8;
    localparam int TICKS_RESET       = 15;
    localparam int SEQ_RESET         = 1;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 16;

    typedef enum logic [1:0] {
        ACT_MSG     = 2'd0,
        ACT_NET     = 2'd1,
        ACT_TIMEOUT = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        KIND_SEND    = 3'd0,
        KIND_START   = 3'd1,
        KIND_STOP    = 3'd2,
        KIND_QUEUED  = 3'd3,
        KIND_FULL    = 3'd4,
        KIND_CORRUPT = 3'd5,
        KIND_STALE   = 3'd6
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE   = 1'b0,
        CFG_TIMEOUT_TICKS = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DECIDE,
        S_QUEUED,
        S_ACKED,
        S_SEND,
        S_TIMER
    } t_state;

    typedef struct packed {
        t_action            action;
        logic [63:0]        data_lo;
        logic [63:0]        data_mid;
        logic [31:0]        data_hi;
        logic signed [31:0] rx_seq;
        logic signed [31:0] rx_ack;
        logic signed [31:0] rx_checksum;
    } t_in;

    typedef struct packed {
        t_kind              kind;
        logic [30:0]        tx_seq;
        logic signed [31:0] tx_checksum;
        logic [63:0]        out_data_lo;
        logic [63:0]        out_data_mid;
        logic [31:0]        out_data_hi;
        logic [15:0]        timer_ticks;
        logic               last;
    } t_out;

endpackage

// ----- hdl/gbn_csum.sv -----
// serial checksum unit: adds the payload as signed bytes, four per cycle
module gbn_csum #(
    parameter int PAYLOAD_BYTES = gbn_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [31:0]                  i_init,
    input  logic [gbn_pkg::PAYLOAD_W-1:0] i_payload,
    output logic                         o_done,
    output logic [31:0]                  o_sum
);
    import gbn_pkg::*;

    localparam int N_GRP = (PAYLOAD_BYTES + 3) / 4;
    localparam int GRP_W = (N_GRP > 1) ? $clog2(N_GRP) : 1;

    logic             r_busy;
    logic             r_done;
    logic [GRP_W-1:0] r_grp;
    logic [31:0]      r_acc;
    logic [31:0]      grp_word;
    logic [31:0]      grp_sum;

    assign grp_word = i_payload[32*r_grp +: 32];

    // four sign-extended bytes of the current group
    always_comb begin
        grp_sum = '0;
        for (int b = 0; b < 4; b++) begin
            grp_sum = grp_sum + {{24{grp_word[8*b+7]}}, grp_word[8*b +: 8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_grp  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_grp  <= '0;
            end else if (r_busy) begin
                if (r_grp == GRP_W'(N_GRP - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_grp <= r_grp + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_init;
        end else if (r_busy) begin
            r_acc <= r_acc + grp_sum;
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc;

endmodule

// ----- hdl/go_back_n_sender_unit.sv -----
// go-back-n sender: packet ring, window and timer control
//
// Go-back-N sender. Messages from the upper layer are numbered from 1, given a
// checksum and kept in a ring of RING_SLOTS slots until acknowledged; a message
// arriving while the ring holds RING_SLOTS unacknowledged packets is dropped.
// Network packets carry cumulative acks; timer expiries resend everything in
// flight. Each input transfer yields one or more result transfers, the final
// one flagged by last. Order of work: the item is taken, messages and network
// packets then pass through the serial checksum unit and have the sum handed
// over, a decision is made, and the results are given, one per cycle while the
// output side takes them; each sent packet costs one read of the ring's single
// read port, issued in the cycle before, so results follow back to back. The input
// is stalled while an item is being worked; the last result may still sit in the
// output register when the next item is taken. The ring contents are undefined
// after reset and need no clearing pass: only slots written earlier are read.
module go_back_n_sender_unit #(
    parameter int RING_SLOTS    = gbn_pkg::RING_SLOTS_DEF,
    parameter int PAYLOAD_BYTES = gbn_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  gbn_pkg::t_in                    i_in,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output gbn_pkg::t_out                   o_out
);
    import gbn_pkg::*;

    localparam int SLOT_W = $clog2(RING_SLOTS);
    localparam int K_W    = $clog2(RING_SLOTS + 1);
    localparam logic [PAYLOAD_W-1:0] PAY_MASK =
        {PAYLOAD_W{1'b1}} >> (PAYLOAD_W - 8 * PAYLOAD_BYTES);

    // one ring entry: checksum and payload
    typedef struct packed {
        logic [31:0] cks;
        logic [31:0] hi;
        logic [63:0] mid;
        logic [63:0] lo;
    } t_entry;

    // slot of seq+1 given the slot of seq; the sequence wraps at 2^32
    function automatic logic [SLOT_W-1:0] next_slot(input logic [31:0] seq,
                                                    input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] res;
        if (seq == '1) begin
            res = '0;
        end else if (slot == SLOT_W'(RING_SLOTS - 1)) begin
            res = '0;
        end else begin
            res = slot + 1'b1;
        end
        return res;
    endfunction

    // packet ring
    t_entry            ring_mem [RING_SLOTS];
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;
    t_entry            mem_wd;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_ra;
    t_entry            r_rd;

    // control state
    t_state            r_state, n_state;
    logic              r_resend, n_resend;
    logic [31:0]       r_base, n_base;
    logic [SLOT_W-1:0] r_base_slot, n_base_slot;
    logic [31:0]       r_nts, n_nts;
    logic [SLOT_W-1:0] r_nts_slot, n_nts_slot;
    logic [31:0]       r_nf, n_nf;
    logic [SLOT_W-1:0] r_nf_slot, n_nf_slot;
    logic [31:0]       r_cur, n_cur;
    logic [SLOT_W-1:0] r_cur_slot, n_cur_slot;
    logic [5:0]        r_ws;
    logic [15:0]       r_ticks;
    logic              r_out_valid;
    t_out              r_out;

    // captured item
    t_action           r_action;
    logic [PAYLOAD_W-1:0] r_pay;
    logic [31:0]       r_ack;
    logic [31:0]       r_cks;

    // checksum unit
    logic              csum_start;
    logic [31:0]       csum_init;
    logic              csum_done;
    logic [31:0]       csum_sum;

    logic              capture;
    logic              emit;
    logic              fire;
    t_out              emit_item;

    // window and ack arithmetic
    logic [5:0]        w_eff;
    logic [31:0]       d_nts_base;
    logic [31:0]       d_nf_nts;
    logic [31:0]       d_nts_cur;
    logic [31:0]       d_nf_base;
    logic              win_go;
    logic              win_go_nx;
    logic              ring_full;
    logic              corrupt;
    logic              stale;
    logic [31:0]       new_base;
    logic [31:0]       ack_k;
    logic              base_wrap;
    logic [K_W:0]      slot_sum;
    logic [K_W:0]      slot_red;
    logic [SLOT_W-1:0] new_base_slot;
    logic [31:0]       cur_seq;

    gbn_csum #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_csum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (csum_start),
        .i_init    (csum_init),
        .i_payload (r_pay),
        .o_done    (csum_done),
        .o_sum     (csum_sum)
    );

    // window size 0 acts as 1, anything above the limit as the limit
    assign w_eff = (r_ws == 6'd0) ? 6'd1 :
                   (r_ws > 6'(WIN_MAX)) ? 6'(WIN_MAX) : r_ws;

    assign d_nts_base = r_nts - r_base;
    assign d_nf_nts   = r_nf - r_nts;
    assign d_nts_cur  = r_nts - r_cur;
    assign d_nf_base  = r_nf - r_base;

    // more to send now, and more to send after the packet at next_to_send
    assign win_go    = (d_nf_nts != 32'd0) && (d_nts_base < {26'd0, w_eff});
    assign win_go_nx = (d_nf_nts != 32'd1) && (d_nts_base < {26'd0, w_eff - 6'd1});
    assign ring_full = d_nf_base >= 32'(RING_SLOTS);

    assign corrupt = csum_sum != r_cks;
    assign stale   = (r_ack - r_base) >= d_nts_base;

    // slot of the new base: the ack distance never exceeds the ring depth;
    // past the 2^32 wrap the new base is small enough to be its own slot
    assign new_base  = r_ack + 32'd1;
    assign ack_k     = new_base - r_base;
    assign base_wrap = new_base < r_base;
    assign slot_sum  = (K_W + 1)'(r_base_slot) + (K_W + 1)'(ack_k[K_W-1:0]);
    assign slot_red  = (slot_sum >= (K_W + 1)'(RING_SLOTS)) ?
                       slot_sum - (K_W + 1)'(RING_SLOTS) : slot_sum;
    assign new_base_slot = base_wrap ? new_base[SLOT_W-1:0] : slot_red[SLOT_W-1:0];

    assign cur_seq = r_resend ? r_cur : r_nts;

    // output register frees when empty or taken this cycle
    assign fire = emit && (!r_out_valid || !i_out_stall);

    assign o_in_stall = (r_state != S_IDLE);
    assign capture    = (r_state == S_IDLE) && i_in_valid;
    assign csum_start = capture && ((i_in.action == ACT_MSG) || (i_in.action == ACT_NET));
    assign csum_init  = (i_in.action == ACT_MSG) ? r_nf : 32'(i_in.rx_seq + i_in.rx_ack);

    // sequencer: next state, results and ring accesses
    always_comb begin
        n_state     = r_state;
        n_resend    = r_resend;
        n_base      = r_base;
        n_base_slot = r_base_slot;
        n_nts       = r_nts;
        n_nts_slot  = r_nts_slot;
        n_nf        = r_nf;
        n_nf_slot   = r_nf_slot;
        n_cur       = r_cur;
        n_cur_slot  = r_cur_slot;
        emit        = 1'b0;
        emit_item   = '0;
        mem_we      = 1'b0;
        mem_wa      = r_nf_slot;
        mem_wd      = {csum_sum, r_pay[159:128], r_pay[127:64], r_pay[63:0]};
        mem_re      = 1'b0;
        mem_ra      = r_nts_slot;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_resend = (i_in.action == ACT_TIMEOUT);
                    if ((i_in.action == ACT_MSG) || (i_in.action == ACT_NET)) begin
                        n_state = S_SUM;
                    end else begin
                        n_state = S_DECIDE;
                    end
                end
            end

            S_SUM: begin
                if (csum_done) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                case (r_action)
                    ACT_MSG: begin
                        if (ring_full) begin
                            emit           = 1'b1;
                            emit_item.kind = KIND_FULL;
                            emit_item.last = 1'b1;
                            if (fire) begin
                                n_state = S_IDLE;
                            end
                        end else begin
                            // store the packet; the queued result follows
                            mem_we    = 1'b1;
                            n_nf      = r_nf + 32'd1;
                            n_nf_slot = next_slot(r_nf, r_nf_slot);
                            n_state   = S_QUEUED;
                        end
                    end
                    ACT_NET: begin
                        if (corrupt || stale) begin
                            emit           = 1'b1;
                            emit_item.kind = corrupt ? KIND_CORRUPT : KIND_STALE;
                            emit_item.last = 1'b1;
                            if (fire) begin
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_base      = new_base;
                            n_base_slot = new_base_slot;
                            n_state     = S_ACKED;
                        end
                    end
                    ACT_TIMEOUT: begin
                        if (r_base != r_nts) begin
                            n_cur      = r_base;
                            n_cur_slot = r_base_slot;
                            mem_re     = 1'b1;
                            mem_ra     = r_base_slot;
                            n_state    = S_SEND;
                        end else begin
                            n_state = S_TIMER;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_QUEUED: begin
                emit           = 1'b1;
                emit_item.kind = KIND_QUEUED;
                emit_item.last = !win_go;
                if (fire) begin
                    if (win_go) begin
                        mem_re  = 1'b1;
                        n_state = S_SEND;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_ACKED: begin
                emit = 1'b1;
                if (r_base == r_nts) begin
                    // nothing outstanding: stop the timer and send on
                    emit_item.kind = KIND_STOP;
                    emit_item.last = !win_go;
                    if (fire) begin
                        if (win_go) begin
                            mem_re  = 1'b1;
                            n_state = S_SEND;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    emit_item.kind        = KIND_START;
                    emit_item.timer_ticks = r_ticks;
                    emit_item.last        = 1'b1;
                    if (fire) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_SEND: begin
                emit                   = 1'b1;
                emit_item.kind         = KIND_SEND;
                emit_item.tx_seq       = cur_seq[30:0];
                emit_item.tx_checksum  = r_rd.cks;
                emit_item.out_data_lo  = r_rd.lo;
                emit_item.out_data_mid = r_rd.mid;
                emit_item.out_data_hi  = r_rd.hi;
                if (r_resend) begin
                    if (fire) begin
                        n_cur      = r_cur + 32'd1;
                        n_cur_slot = next_slot(r_cur, r_cur_slot);
                        if (d_nts_cur != 32'd1) begin
                            mem_re = 1'b1;
                            mem_ra = n_cur_slot;
                        end else begin
                            n_state = S_TIMER;
                        end
                    end
                end else begin
                    // the first packet in flight starts the timer
                    emit_item.last = (r_nts != r_base) && !win_go_nx;
                    if (fire) begin
                        n_nts      = r_nts + 32'd1;
                        n_nts_slot = next_slot(r_nts, r_nts_slot);
                        if (r_nts == r_base) begin
                            n_state = S_TIMER;
                        end else if (win_go_nx) begin
                            mem_re = 1'b1;
                            mem_ra = n_nts_slot;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end

            S_TIMER: begin
                emit                  = 1'b1;
                emit_item.kind        = KIND_START;
                emit_item.timer_ticks = r_ticks;
                emit_item.last        = r_resend || !win_go;
                if (fire) begin
                    if (!r_resend && win_go) begin
                        mem_re  = 1'b1;
                        n_state = S_SEND;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_resend    <= 1'b0;
            r_base      <= 32'(SEQ_RESET);
            r_base_slot <= SLOT_W'(SEQ_RESET);
            r_nts       <= 32'(SEQ_RESET);
            r_nts_slot  <= SLOT_W'(SEQ_RESET);
            r_nf        <= 32'(SEQ_RESET);
            r_nf_slot   <= SLOT_W'(SEQ_RESET);
            r_cur       <= 32'(SEQ_RESET);
            r_cur_slot  <= SLOT_W'(SEQ_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_resend    <= n_resend;
            r_base      <= n_base;
            r_base_slot <= n_base_slot;
            r_nts       <= n_nts;
            r_nts_slot  <= n_nts_slot;
            r_nf        <= n_nf;
            r_nf_slot   <= n_nf_slot;
            r_cur       <= n_cur;
            r_cur_slot  <= n_cur_slot;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws    <= 6'(WINDOW_RESET);
            r_ticks <= 16'(TICKS_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_SIZE:   r_ws    <= i_cfg_wdata[5:0];
                CFG_TIMEOUT_TICKS: r_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= emit_item;
        end
        if (capture) begin
            r_action <= i_in.action;
            r_pay    <= {i_in.data_hi, i_in.data_mid, i_in.data_lo} & PAY_MASK;
            r_ack    <= i_in.rx_ack;
            r_cks    <= i_in.rx_checksum;
        end
    end

    // ring: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            ring_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= ring_mem[mem_ra];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- hdl/gbn_check.sv -----
// port checker for the go-back-n sender, bound to the top level
`include "go_back_n_sender_unit_defines.svh"

module gbn_check (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input gbn_pkg::t_out                   o_out
);
    import gbn_pkg::*;

    // a stalled result holds
    `GBN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "stalled result changed")

    // an accepted item keeps the input stalled while it is worked
    `GBN_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken twice in a row")

    // only packet transfers carry packet fields
    `GBN_ASSERT_NOW(a_pkt_zero, i_clk, i_rst_n, o_out_valid && (o_out.kind != KIND_SEND), (o_out.tx_seq == 31'd0) && (o_out.tx_checksum == 32'sd0) && (o_out.out_data_lo == 64'd0), "packet fields on non-send")

    // only start-timer transfers carry a duration
    `GBN_ASSERT_NOW(a_ticks_zero, i_clk, i_rst_n, o_out_valid && (o_out.kind != KIND_START), o_out.timer_ticks == 16'd0, "ticks on non-start result")

endmodule

bind go_back_n_sender_unit gbn_check u_gbn_check (.*);
